// ===== rtl/core/lrkf_pkg.sv =====
// Shared types and constants for the recent-key filter.
package lrkf_pkg;

	localparam int unsigned CAP_BITS = 7;
	localparam int unsigned OCC_BITS = 7;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MATCH,
		PH_UPDATE
	} phase_t;

endpackage

// ===== rtl/core/lrkf_cell.sv =====
// One entry of the recency chain: key storage, match compare and shift toward the back.
module lrkf_cell #(
	parameter int unsigned KEY_BITS = 64,
	parameter int unsigned CNT_BITS = 7,
	parameter int unsigned IDX_BITS = 6,
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic [KEY_BITS-1:0] lookup_key,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [CNT_BITS-1:0] count,
	input  logic [IDX_BITS-1:0] limit,
	input  logic                update,
	output logic [KEY_BITS-1:0] stored_key,
	output logic                match
);

	logic [KEY_BITS-1:0] key_q;

	always_ff @(posedge clk) begin
		if (update && (IDX_BITS'(IDX) <= limit)) begin
			key_q <= prev_key;
		end
	end

	assign stored_key = key_q;
	assign match = (count > CNT_BITS'(IDX)) && (key_q == lookup_key);

endmodule

// ===== rtl/core/lrkf_encode.sv =====
// One-hot match vector to hit flag and binary position.
module lrkf_encode #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned IDX_BITS = 6
) (
	input  logic [ENTRIES-1:0]  onehot,
	output logic                hit,
	output logic [IDX_BITS-1:0] pos
);

	always_comb begin
		pos = '0;
		for (int unsigned i = 0; i < ENTRIES; i++) begin
			if (onehot[i]) begin
				pos = pos | IDX_BITS'(i);
			end
		end
	end

	assign hit = |onehot;

endmodule

// ===== rtl/core/lru_recent_key_filter.sv =====
// Recent-key filter top level: chain of key cells, sequencer and output register.
//
// Keeps up to ENTRIES keys in recency order in a row of cells, cell 0 the most
// recent. An item passes a match phase, then an update phase: in the first
// all cells compare their key with the incoming one, in the second the hit
// position (or the occupancy on a miss) picks which cells shift one place
// back while the key enters cell 0, and the result is loaded into the output
// register, the update phase waiting while that register holds a result not
// yet taken. A new key is taken only in the idle phase, after the previous one
// has left the cells. Capacity is written on the cfg channel, which is always
// ready; values above ENTRIES act as ENTRIES. Output tdata: bit 0 fetch_needed,
// bits 7:1 occupancy.
module lru_recent_key_filter #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned KEY_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrkf_pkg::CAP_BITS-1:0]     cfg_data,   // capacity
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0]     s_tdata,    // key
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata     // fetch_needed, occupancy
);

	localparam int unsigned IDX_BITS = $clog2(ENTRIES);
	localparam int unsigned CNT_BITS = $clog2(ENTRIES + 1);
	localparam int unsigned CMP_BITS = (CNT_BITS > lrkf_pkg::CAP_BITS) ?
		CNT_BITS : lrkf_pkg::CAP_BITS;

	lrkf_pkg::phase_t phase_q, phase_next;

	logic [lrkf_pkg::CAP_BITS-1:0] cap_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [CNT_BITS-1:0]           count_q, count_next;
	logic [ENTRIES-1:0]            match_vec, match_s1;
	logic [KEY_BITS-1:0]           cell_key [ENTRIES];
	logic                          hit;
	logic [IDX_BITS-1:0]           pos;
	logic [IDX_BITS-1:0]           limit;
	logic                          replace;
	logic                          advance;
	logic                          capture;
	logic                          fetch_q;
	logic [lrkf_pkg::OCC_BITS-1:0] occ_q;
	logic                          out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrkf_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			lrkf_pkg::PH_IDLE: begin
				if (s_tvalid) begin
					phase_next = lrkf_pkg::PH_MATCH;
				end
			end
			lrkf_pkg::PH_MATCH: begin
				phase_next = lrkf_pkg::PH_UPDATE;
			end
			lrkf_pkg::PH_UPDATE: begin
				if (!out_valid_q || m_tready) begin
					phase_next = lrkf_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_next = lrkf_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		capture  = 1'b0;
		advance  = 1'b0;
		case (phase_q)
			lrkf_pkg::PH_IDLE: begin
				s_tready = 1'b1;
			end
			lrkf_pkg::PH_MATCH: begin
				capture = 1'b1;
			end
			lrkf_pkg::PH_UPDATE: begin
				advance = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrkf_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_q <= s_tdata[KEY_BITS-1:0];
		end
		if (capture) begin
			match_s1 <= match_vec;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lrkf_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_BITS (CNT_BITS),
			.IDX_BITS (IDX_BITS),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.lookup_key (key_q),
			.prev_key   ((i == 0) ? key_q : cell_key[(i == 0) ? 0 : i - 1]),
			.count      (count_q),
			.limit      (limit),
			.update     (advance),
			.stored_key (cell_key[i]),
			.match      (match_vec[i])
		);
	end

	lrkf_encode #(
		.ENTRIES  (ENTRIES),
		.IDX_BITS (IDX_BITS)
	) u_encode (
		.onehot (match_s1),
		.hit    (hit),
		.pos    (pos)
	);

	always_comb begin
		replace = !hit && (count_q != '0) &&
			((CMP_BITS'(count_q) >= CMP_BITS'(cap_q)) ||
			 (count_q == CNT_BITS'(ENTRIES)));
		if (hit) begin
			limit      = pos;
			count_next = count_q;
		end else if (replace) begin
			limit      = IDX_BITS'(count_q - CNT_BITS'(1));
			count_next = count_q;
		end else begin
			limit      = IDX_BITS'(count_q);
			count_next = count_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fetch_q <= !hit;
			occ_q   <= lrkf_pkg::OCC_BITS'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {occ_q, fetch_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(ENTRIES))
		else $error("occupancy beyond entry count");

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lrkf_pkg::PH_UPDATE) |-> $onehot0(match_s1))
		else $error("key stored in more than one valid cell");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && hit) |=> (count_q == $past(count_q)))
		else $error("occupancy changed on a hit");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result not presented after update");

	a_miss_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !hit && !replace) |=> (count_q == $past(count_q) + CNT_BITS'(1)))
		else $error("occupancy did not grow on insert");

endmodule

// ===== tb/sv/tb_lru_recent_key_filter.sv =====
// Testbench for lru_recent_key_filter: predicts hit/miss and occupancy per key and checks each result.
module tb_lru_recent_key_filter;

	localparam int unsigned ENTRIES     = 64;
	localparam int unsigned KEY_BITS    = 64;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS = 10;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_PATTERN,
		RX_LONG
	} rx_mode_t;

	typedef struct {
		logic [KEY_BITS-1:0]           key;
		logic                          fetch;
		logic [lrkf_pkg::OCC_BITS-1:0] occ;
	} lookup_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [lrkf_pkg::CAP_BITS-1:0] cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [63:0]                   s_tdata;    // key
	logic                          m_tvalid;
	logic                          m_tready;
	logic [7:0]                    m_tdata;    // fetch_needed, occupancy

	logic [KEY_BITS-1:0]           recent_keys [ENTRIES];
	int unsigned                   recent_count;
	logic [lrkf_pkg::CAP_BITS-1:0] capacity_reg;
	lookup_result_t                pending_lookups [$];
	lookup_result_t                oldest_lookup;

	bit          sender_gaps;
	int unsigned burst_left;
	rx_mode_t    rx_mode = RX_COIN;
	int unsigned rx_tick = 0;
	int unsigned rx_hold = 0;
	int unsigned quiet_cycles = 0;

	int unsigned fail_count = 0;
	int unsigned keys_sent = 0;
	int unsigned results_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned misses_seen = 0;
	int unsigned peak_occupancy = 0;
	int unsigned capacity_writes = 0;

	lru_recent_key_filter #(
		.ENTRIES(ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [KEY_BITS-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic lookup_result_t lookup_recent(input logic [KEY_BITS-1:0] key);
		int unsigned    cap;
		int unsigned    n;
		int unsigned    last;
		bit             hit;
		lookup_result_t r;
		cap = (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
		n = recent_count;
		hit = 1'b0;
		last = 0;
		for (int i = 0; i < n; i++) begin
			if (!hit && recent_keys[i] == key) begin
				hit = 1'b1;
				last = i;
			end
		end
		if (!hit) begin
			if (n > 0 && (n >= cap || n >= ENTRIES)) begin
				last = n - 1;
			end else begin
				last = n;
				n++;
			end
		end
		for (int i = last; i > 0; i--)
			recent_keys[i] = recent_keys[i-1];
		recent_keys[0] = key;
		recent_count = n;
		if (n > peak_occupancy)
			peak_occupancy = n;
		r.key = key;
		r.fetch = !hit;
		r.occ = lrkf_pkg::OCC_BITS'(n);
		return r;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch: %s", what);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_lookups.size() == 0) begin
				note_failure($sformatf("unexpected result fetch %0d occupancy %0d",
					m_tdata[0], m_tdata[7:1]));
			end else begin
				oldest_lookup = pending_lookups.pop_front();
				if (oldest_lookup.fetch)
					misses_seen++;
				else
					hits_seen++;
				if (m_tdata[0] !== oldest_lookup.fetch || m_tdata[7:1] !== oldest_lookup.occ)
					note_failure($sformatf(
						"key %h: expected fetch %0d occupancy %0d, got fetch %0d occupancy %0d",
						oldest_lookup.key, oldest_lookup.fetch, oldest_lookup.occ,
						m_tdata[0], m_tdata[7:1]));
			end
		end
	end

	always @(negedge clk) begin
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS: m_tready = 1'b1;
			RX_COIN: m_tready = $urandom_range(0, 1);
			RX_PATTERN: m_tready = (rx_tick % 7) < 4;
			RX_LONG: begin
				if (rx_hold == 0) begin
					m_tready = ~m_tready;
					rx_hold = m_tready ? $urandom_range(1, 10) : $urandom_range(1, 20);
				end else begin
					rx_hold--;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_key(input logic [KEY_BITS-1:0] key);
		int unsigned gap;
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 1'b0;
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = key;
		do @(posedge clk); while (!s_tready);
		pending_lookups.push_back(lookup_recent(key));
		keys_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lrkf_pkg::CAP_BITS-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = value;
		capacity_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_random_phase(input logic [lrkf_pkg::CAP_BITS-1:0] cap,
			input int unsigned pool_size, input int unsigned count, input bit gaps,
			input rx_mode_t mode);
		logic [KEY_BITS-1:0] pool [$];
		logic [KEY_BITS-1:0] base_key;
		logic [KEY_BITS-1:0] key;
		write_capacity(cap);
		sender_gaps = gaps;
		rx_mode = mode;
		burst_left = 0;
		base_key = random_key();
		for (int i = 0; i < pool_size; i++)
			pool.push_back((i % 2) ? random_key() : base_key ^ (64'd1 << (i % KEY_BITS)));
		repeat (count) begin
			if ($urandom_range(0, 9) < 8)
				key = pool[$urandom_range(0, pool_size - 1)];
			else
				key = random_key();
			send_key(key);
		end
	endtask

	task automatic test_capacity_zero();
		logic [KEY_BITS-1:0] k1;
		k1 = random_key();
		write_capacity(7'd0);
		send_key(k1);
		send_key(k1);
		send_key(k1 ^ 64'd1);
		send_key(k1);
	endtask

	task automatic test_key_extremes();
		write_capacity(7'd127);
		send_key(64'd0);
		send_key({64{1'b1}});
		send_key(64'd0);
		send_key({32{2'b10}});
		send_key({32{2'b01}});
		send_key({64{1'b1}});
		send_key({1'b1, 62'd0, 1'b1});
	endtask

	task automatic test_capacity_lowered();
		logic [KEY_BITS-1:0] fresh;
		fresh = random_key();
		write_capacity(7'd2);
		send_key(64'd0);
		send_key(fresh);
		send_key(fresh);
		send_key({32{2'b01}});
	endtask

	task automatic test_capacity_one();
		logic [KEY_BITS-1:0] k1;
		k1 = random_key();
		write_capacity(7'd1);
		send_key(k1);
		send_key(k1);
		send_key(~k1);
	endtask

	task automatic test_full_capacity();
		run_random_phase(7'd64, 96, 480, 1'b1, RX_COIN);
		run_random_phase(7'd64, 40, 100, 1'b0, RX_ALWAYS);
	endtask

	task automatic test_above_entries();
		run_random_phase(7'd127, 80, 150, 1'b1, RX_PATTERN);
		run_random_phase(7'd65, 70, 100, 1'b1, RX_LONG);
	endtask

	task automatic test_tiny_capacity();
		run_random_phase(7'd1, 3, 120, 1'b1, RX_LONG);
		run_random_phase(7'd0, 3, 100, 1'b1, RX_COIN);
	endtask

	task automatic test_random_capacity();
		int unsigned cap;
		for (int p = 0; p < 3; p++) begin
			cap = $urandom_range(2, 63);
			run_random_phase(lrkf_pkg::CAP_BITS'(cap), cap + cap / 2 + 1, 110, p != 1,
				(p == 1) ? RX_ALWAYS : RX_PATTERN);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		capacity_reg = lrkf_pkg::CAP_RESET;
		recent_count = 0;
		sender_gaps = 1'b1;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_capacity_zero();
		test_key_extremes();
		test_capacity_lowered();
		test_capacity_one();
		test_full_capacity();
		test_above_entries();
		test_tiny_capacity();
		test_random_capacity();

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_lookups.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_lookups.size()));
		$display("Ran %0d key lookups across %0d capacity writes, %0d results checked",
			keys_sent, capacity_writes, results_seen);
		$display("Saw %0d hits and %0d misses, peak occupancy %0d, %0d failures",
			hits_seen, misses_seen, peak_occupancy, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
